// ===== rtl/lru_byte_budget_cache_policy_assert.svh =====
// Assertion macros for the LRU byte budget cache policy RTL.
`ifndef LRU_BYTE_BUDGET_CACHE_POLICY_ASSERT_SVH
`define LRU_BYTE_BUDGET_CACHE_POLICY_ASSERT_SVH

`ifndef ASSERT_OFF
`define LBB_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define LBB_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define LBB_ASSERT(lbl, clk, rstn, prop, msg)
`define LBB_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

// ===== rtl/lbb_pkg.sv =====
`default_nettype none

package lbb_pkg;

  localparam int unsigned KEY_W    = 31;
  localparam int unsigned SIZE_W   = 32;
  localparam int unsigned USED_W   = 37;
  localparam int unsigned BUDGET_W = 16;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned MB_SHIFT = 20;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_HIT      = 3'd0,
    KIND_MISS     = 3'd1,
    KIND_EVICTED  = 3'd2,
    KIND_INSERTED = 3'd3,
    KIND_CLEARED  = 3'd4,
    KIND_REFUSED  = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DECODE,
    B_EVICT,
    B_INSERT
  } back_state_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [KEY_W-1:0]  key;
    logic [SIZE_W-1:0] size;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

endpackage

`default_nettype wire

// ===== rtl/lbb_front.sv =====
`default_nettype none

`include "lru_byte_budget_cache_policy_assert.svh"

module lbb_front (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           start,
  output logic                          busy,
  input  wire  [1:0]                    in_cmd,
  input  wire  [lbb_pkg::KEY_W-1:0]     in_frame_number,
  input  wire  [lbb_pkg::SIZE_W-1:0]    in_frame_size,
  output lbb_pkg::queue_head_t          head,
  input  wire                           pop
);

  lbb_pkg::item_t q_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           push;
  logic           do_pop;

  assign busy   = (cnt_r == 2'd2);
  assign push   = start && !busy;
  assign do_pop = pop && (cnt_r != 2'd0);

  assign head.valid = (cnt_r != 2'd0);
  assign head.item  = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= '{cmd: lbb_pkg::cmd_t'(in_cmd), key: in_frame_number,
                         size: in_frame_size};
    end
  end

  `LBB_NEVER(a_cnt_range, clk, rst_n, cnt_r == 2'd3, "queue count out of range")
  `LBB_ASSERT(a_ptr_gap, clk, rst_n, (cnt_r != 2'd1) || (wr_ptr_r != rd_ptr_r), "ptr mismatch")
  `LBB_ASSERT(a_pop_dec, clk, rst_n, (do_pop && !push) |=> (cnt_r == $past(cnt_r) - 2'd1), "pop lost")

endmodule

`default_nettype wire

// ===== rtl/lbb_back.sv =====
`default_nettype none

`include "lru_byte_budget_cache_policy_assert.svh"

module lbb_back #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             cfg_we,
  input  wire  [lbb_pkg::BUDGET_W-1:0]    cfg_wdata,
  input  lbb_pkg::queue_head_t            head,
  output logic                            pop,
  output logic                            out_valid,
  output logic [lbb_pkg::KIND_W-1:0]      out_kind,
  output logic [lbb_pkg::KEY_W-1:0]       out_frame_number_out,
  output logic [lbb_pkg::SLOT_W-1:0]      out_slot,
  output logic [lbb_pkg::USED_W-1:0]      out_used_bytes,
  output logic                            out_last
);

  localparam int unsigned IW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned BW = lbb_pkg::BUDGET_W + lbb_pkg::MB_SHIFT;
  localparam int unsigned UW = lbb_pkg::USED_W;

  lbb_pkg::back_state_t state_r, state_nxt;
  lbb_pkg::item_t       cur_r;
  logic [lbb_pkg::BUDGET_W-1:0] budget_mb_r;

  logic                      valid_r [MAX_ENTRIES];
  logic [lbb_pkg::KEY_W-1:0] key_r   [MAX_ENTRIES];
  logic [lbb_pkg::SIZE_W-1:0] bytes_r [MAX_ENTRIES];
  logic [IW-1:0]             rank_r  [MAX_ENTRIES];
  logic [UW-1:0]             total_r, total_nxt;
  logic [CW-1:0]             count_r;

  logic                      out_valid_r;
  lbb_pkg::kind_t            out_kind_r, kind_c;
  logic [lbb_pkg::KEY_W-1:0] out_key_r, key_c;
  logic [lbb_pkg::SLOT_W-1:0] out_slot_r, slot_c;
  logic [UW-1:0]             out_used_r;
  logic                      out_last_r, last_c, emit_c;

  logic          hit_any, old_any;
  logic [IW-1:0] hit_idx, old_idx, free_idx;
  logic [BW-1:0] budget;
  logic          over, nofit, need_trim, full;
  logic          do_hit, do_clear, do_evict, do_insert;

  assign budget = {budget_mb_r, {lbb_pkg::MB_SHIFT{1'b0}}};
  assign over   = total_r > UW'(budget);
  assign nofit  = UW'(cur_r.size) > (UW'(budget) - total_r);
  assign need_trim = (count_r != '0) && (over || nofit);
  assign full   = (count_r >= CW'(MAX_ENTRIES));

  always_comb begin
    hit_any  = 1'b0;
    old_any  = 1'b0;
    hit_idx  = '0;
    old_idx  = '0;
    free_idx = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && key_r[i] == cur_r.key) begin
        hit_any = 1'b1;
        hit_idx = IW'(i);
      end
      if (valid_r[i] && (CW'(rank_r[i]) + CW'(1)) == count_r) begin
        old_any = 1'b1;
        old_idx = IW'(i);
      end
      if (!valid_r[i]) begin
        free_idx = IW'(i);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lbb_pkg::B_IDLE: begin
        if (head.valid) begin
          state_nxt = lbb_pkg::B_DECODE;
        end
      end
      lbb_pkg::B_DECODE: begin
        if (cur_r.cmd == lbb_pkg::CMD_INSERT && budget_mb_r != '0 && !hit_any) begin
          state_nxt = lbb_pkg::B_EVICT;
        end else begin
          state_nxt = lbb_pkg::B_IDLE;
        end
      end
      lbb_pkg::B_EVICT: begin
        if (!need_trim) begin
          state_nxt = lbb_pkg::B_INSERT;
        end
      end
      lbb_pkg::B_INSERT: state_nxt = lbb_pkg::B_IDLE;
      default:           state_nxt = lbb_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    emit_c    = 1'b0;
    kind_c    = lbb_pkg::KIND_MISS;
    key_c     = cur_r.key;
    slot_c    = '0;
    last_c    = 1'b1;
    do_hit    = 1'b0;
    do_clear  = 1'b0;
    do_evict  = 1'b0;
    do_insert = 1'b0;
    case (state_r)
      lbb_pkg::B_IDLE: pop = head.valid;
      lbb_pkg::B_DECODE: begin
        case (cur_r.cmd)
          lbb_pkg::CMD_LOOKUP: begin
            emit_c = 1'b1;
            if (hit_any) begin
              kind_c = lbb_pkg::KIND_HIT;
              slot_c = lbb_pkg::SLOT_W'(hit_idx);
              do_hit = 1'b1;
            end
          end
          lbb_pkg::CMD_CLEAR: begin
            emit_c   = 1'b1;
            kind_c   = lbb_pkg::KIND_CLEARED;
            key_c    = '0;
            do_clear = 1'b1;
          end
          lbb_pkg::CMD_INSERT: begin
            if (budget_mb_r == '0) begin
              emit_c = 1'b1;
              kind_c = lbb_pkg::KIND_REFUSED;
            end else if (hit_any) begin
              emit_c = 1'b1;
              kind_c = lbb_pkg::KIND_REFUSED;
              slot_c = lbb_pkg::SLOT_W'(hit_idx);
            end
          end
          default: emit_c = 1'b0;
        endcase
      end
      lbb_pkg::B_EVICT: begin
        if ((need_trim || full) && old_any) begin
          emit_c   = 1'b1;
          kind_c   = lbb_pkg::KIND_EVICTED;
          key_c    = key_r[old_idx];
          slot_c   = lbb_pkg::SLOT_W'(old_idx);
          last_c   = 1'b0;
          do_evict = 1'b1;
        end
      end
      lbb_pkg::B_INSERT: begin
        emit_c    = 1'b1;
        kind_c    = lbb_pkg::KIND_INSERTED;
        slot_c    = lbb_pkg::SLOT_W'(free_idx);
        do_insert = 1'b1;
      end
      default: emit_c = 1'b0;
    endcase
  end

  always_comb begin
    total_nxt = total_r;
    if (do_clear) begin
      total_nxt = '0;
    end else if (do_evict) begin
      total_nxt = total_r - UW'(bytes_r[old_idx]);
    end else if (do_insert) begin
      total_nxt = total_r + UW'(cur_r.size);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lbb_pkg::B_IDLE;
      budget_mb_r <= '0;
      total_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= emit_c;
      total_r     <= total_nxt;
      if (cfg_we) begin
        budget_mb_r <= cfg_wdata;
      end
      if (do_clear) begin
        count_r <= '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          valid_r[i] <= 1'b0;
        end
      end else if (do_evict) begin
        count_r          <= count_r - CW'(1);
        valid_r[old_idx] <= 1'b0;
      end else if (do_insert) begin
        count_r           <= count_r + CW'(1);
        valid_r[free_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head.item;
    end
    out_kind_r <= kind_c;
    out_key_r  <= key_c;
    out_slot_r <= slot_c;
    out_used_r <= total_nxt;
    out_last_r <= last_c;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (do_hit) begin
        if (IW'(i) == hit_idx) begin
          rank_r[i] <= '0;
        end else if (valid_r[i] && rank_r[i] < rank_r[hit_idx]) begin
          rank_r[i] <= rank_r[i] + IW'(1);
        end
      end else if (do_insert) begin
        if (IW'(i) == free_idx) begin
          rank_r[i] <= '0;
        end else if (valid_r[i]) begin
          rank_r[i] <= rank_r[i] + IW'(1);
        end
      end
    end
    if (do_insert) begin
      key_r[free_idx]   <= cur_r.key;
      bytes_r[free_idx] <= cur_r.size;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_kind             = out_kind_r;
  assign out_frame_number_out = out_key_r;
  assign out_slot             = out_slot_r;
  assign out_used_bytes       = out_used_r;
  assign out_last             = out_last_r;

  `LBB_NEVER(a_count_max, clk, rst_n, count_r > CW'(MAX_ENTRIES), "entry count overflow")
  `LBB_ASSERT(a_insert_room, clk, rst_n, do_insert |-> !full, "insert into full table")
  `LBB_ASSERT(a_word_source, clk, rst_n, out_valid |-> $past(state_r) != lbb_pkg::B_IDLE, "word from idle")

endmodule

`default_nettype wire

// ===== rtl/lru_byte_budget_cache_policy.sv =====
// Channel   Ports                                                  Handshake
// input     in_cmd, in_frame_number, in_frame_size                 start / busy
// result    out_kind, out_frame_number_out, out_slot,              out_valid strobe
//           out_used_bytes, out_last
// config    cfg_wdata                                              cfg_we
//
// Words enter a two-deep queue; the back end pops one every idle cycle.
// Lookup, clear and refused insert emit their result from the decode state; an
// insert evicts one entry per cycle while over budget or full, then inserts.
// busy is high only while the queue is full. Results cannot be stalled.
// Synchronous active-low reset empties the table, queue and budget.
`default_nettype none

module lru_byte_budget_cache_policy #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             start,
  output logic                            busy,
  input  wire  [1:0]                      in_cmd,
  input  wire  [lbb_pkg::KEY_W-1:0]       in_frame_number,
  input  wire  [lbb_pkg::SIZE_W-1:0]      in_frame_size,
  input  wire                             cfg_we,
  input  wire  [lbb_pkg::BUDGET_W-1:0]    cfg_wdata,
  output logic                            out_valid,
  output logic [lbb_pkg::KIND_W-1:0]      out_kind,
  output logic [lbb_pkg::KEY_W-1:0]       out_frame_number_out,
  output logic [lbb_pkg::SLOT_W-1:0]      out_slot,
  output logic [lbb_pkg::USED_W-1:0]      out_used_bytes,
  output logic                            out_last
);

  lbb_pkg::queue_head_t head;
  logic                 pop;

  lbb_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_frame_number (in_frame_number),
    .in_frame_size   (in_frame_size),
    .head            (head),
    .pop             (pop)
  );

  lbb_back #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .head                 (head),
    .pop                  (pop),
    .out_valid            (out_valid),
    .out_kind             (out_kind),
    .out_frame_number_out (out_frame_number_out),
    .out_slot             (out_slot),
    .out_used_bytes       (out_used_bytes),
    .out_last             (out_last)
  );

endmodule

`default_nettype wire
